[sv/srq_pkg.sv]
// package with shared constants, types and command/status structs for the range power query
package srq_pkg;

    localparam int ARRAY_DEPTH = 4096;
    localparam int VALUE_RANGE = 65536;

    localparam int IDX_W = 12;
    localparam int VAL_W = 16;
    localparam int POW_W = 40;

    localparam int EL_AW = $clog2(ARRAY_DEPTH);
    localparam int WIN_W = $clog2(ARRAY_DEPTH + 1);
    localparam int CT_AW = $clog2(VALUE_RANGE);
    localparam int CNT_W = WIN_W;
    localparam int FAC_W = CNT_W + 1;
    localparam int DEL_W = FAC_W + VAL_W;

    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = IDX_LSB + IDX_W;
    localparam int LEFT_LSB  = VAL_LSB + VAL_W;
    localparam int RIGHT_LSB = LEFT_LSB + IDX_W;
    localparam int IN_BITS   = RIGHT_LSB + IDX_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((POW_W + 7) / 8) * 8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_VAL,
        ST_CNT,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MV_GROW_LEFT,
        MV_GROW_RIGHT,
        MV_SHRINK_LEFT,
        MV_SHRINK_RIGHT
    } t_move;

    typedef struct packed {
        logic  accept;
        logic  clear_step;
        logic  step;
        t_move move;
        logic  load_done;
        logic  fetch;
        logic  calc;
        logic  update;
        logic  out_load;
    } t_srq_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_load;
        logic in_bad;
        logic grow_left;
        logic grow_right;
        logic shrink_left;
        logic shrink_right;
        logic win_open;
        logic out_free;
    } t_srq_stat;

endpackage

[sv/srq_ram.sv]
// generic single-port-write, single-port-read memory with registered read
module srq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/srq_ctrl.sv]
// controller state machine sequencing clear, window moves, loads and result hand-off
module srq_ctrl
    import srq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    input  t_srq_stat i_stat,
    output t_srq_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_is_load, n_is_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_is_load <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_load <= n_is_load;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_is_load       = r_is_load;
        o_cmd           = '0;
        o_cmd.move      = MV_GROW_LEFT;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_is_load    = i_stat.in_load;
                    if (!i_stat.in_load && i_stat.in_bad) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                if (r_is_load) begin
                    if (i_stat.win_open) begin
                        o_cmd.step = 1'b1;
                        o_cmd.move = MV_SHRINK_LEFT;
                        n_state    = ST_VAL;
                    end else begin
                        o_cmd.load_done = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else if (i_stat.grow_left) begin
                    o_cmd.step = 1'b1;
                    o_cmd.move = MV_GROW_LEFT;
                    n_state    = ST_VAL;
                end else if (i_stat.grow_right) begin
                    o_cmd.step = 1'b1;
                    o_cmd.move = MV_GROW_RIGHT;
                    n_state    = ST_VAL;
                end else if (i_stat.shrink_left) begin
                    o_cmd.step = 1'b1;
                    o_cmd.move = MV_SHRINK_LEFT;
                    n_state    = ST_VAL;
                end else if (i_stat.shrink_right) begin
                    o_cmd.step = 1'b1;
                    o_cmd.move = MV_SHRINK_RIGHT;
                    n_state    = ST_VAL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_VAL: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_CNT;
            end
            ST_CNT: begin
                o_cmd.calc = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_MOVE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/srq_dp.sv]
// datapath: element store, count table, window bounds, running power and output register
module srq_dp
    import srq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_srq_cmd              i_cmd,
    output t_srq_stat             o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,
    input  logic                  i_m_axis_tready,
    output logic                  o_m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser
);

    logic [IDX_W-1:0] w_idx, w_left, w_right;
    logic [VAL_W-1:0] w_val;

    assign w_idx   = i_s_axis_tdata[IDX_LSB +: IDX_W];
    assign w_val   = i_s_axis_tdata[VAL_LSB +: VAL_W];
    assign w_left  = i_s_axis_tdata[LEFT_LSB +: IDX_W];
    assign w_right = i_s_axis_tdata[RIGHT_LSB +: IDX_W];

    logic [WIN_W-1:0] r_start, r_end, r_q_left, r_q_stop;
    logic [EL_AW-1:0] r_ld_idx;
    logic [VAL_W-1:0] r_ld_val, r_val;
    logic             r_ld_ok, r_q_err;
    logic [CT_AW-1:0] r_clr;
    logic             r_add, r_skip;
    logic [DEL_W-1:0] r_delta;
    logic [CNT_W-1:0] r_newk;
    logic [POW_W-1:0] r_power;
    logic             r_out_valid;
    logic [POW_W-1:0] r_out_power;
    logic             r_out_err;

    logic [WIN_W-1:0] w_pos;
    logic [VAL_W-1:0] w_el_rdata;
    logic [CNT_W-1:0] w_cnt_rdata;
    logic             w_ct_we;
    logic [CT_AW-1:0] w_ct_waddr;
    logic [CNT_W-1:0] w_ct_wdata;
    logic [FAC_W-1:0] w_factor;
    logic             w_in_bad, w_ld_ok;

    assign w_in_bad = (w_left > w_right) || (32'(w_right) >= ARRAY_DEPTH);
    assign w_ld_ok  = (32'(w_idx) < ARRAY_DEPTH) && (32'(w_val) < VALUE_RANGE);

    always_comb begin
        unique case (i_cmd.move)
            MV_GROW_LEFT:    w_pos = r_start - WIN_W'(1);
            MV_GROW_RIGHT:   w_pos = r_end;
            MV_SHRINK_LEFT:  w_pos = r_start;
            MV_SHRINK_RIGHT: w_pos = r_end - WIN_W'(1);
            default:         w_pos = r_start;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_power     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + CT_AW'(1);
            end
            if (i_cmd.step) begin
                unique case (i_cmd.move)
                    MV_GROW_LEFT:    r_start <= r_start - WIN_W'(1);
                    MV_GROW_RIGHT:   r_end   <= r_end + WIN_W'(1);
                    MV_SHRINK_LEFT:  r_start <= r_start + WIN_W'(1);
                    MV_SHRINK_RIGHT: r_end   <= r_end - WIN_W'(1);
                    default:         r_start <= r_start;
                endcase
            end
            if (i_cmd.load_done) begin
                r_start <= '0;
                r_end   <= '0;
            end
            if (i_cmd.update && !r_skip) begin
                if (r_add) begin
                    r_power <= r_power + POW_W'(r_delta);
                end else begin
                    r_power <= r_power - POW_W'(r_delta);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // multiplier operand: 2k+1 on add, 2k-1 on remove
    always_comb begin
        if (r_add) begin
            w_factor = {w_cnt_rdata, 1'b1};
        end else begin
            w_factor = {w_cnt_rdata, 1'b0} - FAC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q_left <= WIN_W'(w_left);
            r_q_stop <= WIN_W'(w_right) + WIN_W'(1);
            r_ld_idx <= EL_AW'(w_idx);
            r_ld_val <= w_val;
            r_ld_ok  <= w_ld_ok;
            r_q_err  <= w_in_bad;
        end
        if (i_cmd.step) begin
            r_add <= (i_cmd.move == MV_GROW_LEFT) || (i_cmd.move == MV_GROW_RIGHT);
        end
        if (i_cmd.fetch) begin
            r_val <= w_el_rdata;
        end
        if (i_cmd.calc) begin
            r_delta <= DEL_W'(w_factor) * DEL_W'(r_val);
            r_skip  <= !r_add && (w_cnt_rdata == '0);
            r_newk  <= r_add ? w_cnt_rdata + CNT_W'(1) : w_cnt_rdata - CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_power <= r_q_err ? '0 : r_power;
            r_out_err   <= r_q_err;
        end
    end

    srq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ARRAY_DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_done && r_ld_ok),
        .i_waddr (r_ld_idx),
        .i_wdata (r_ld_val),
        .i_raddr (w_pos[EL_AW-1:0]),
        .o_rdata (w_el_rdata)
    );

    assign w_ct_we    = i_cmd.clear_step || (i_cmd.update && !r_skip);
    assign w_ct_waddr = i_cmd.clear_step ? r_clr : CT_AW'(r_val);
    assign w_ct_wdata = i_cmd.clear_step ? '0 : r_newk;

    srq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_RANGE)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_ct_we),
        .i_waddr (w_ct_waddr),
        .i_wdata (w_ct_wdata),
        .i_raddr (CT_AW'(w_el_rdata)),
        .o_rdata (w_cnt_rdata)
    );

    always_comb begin
        o_stat.clr_last     = (32'(r_clr) == VALUE_RANGE - 1);
        o_stat.in_load      = (i_s_axis_tuser == CMD_LOAD);
        o_stat.in_bad       = w_in_bad;
        o_stat.grow_left    = r_q_left < r_start;
        o_stat.grow_right   = r_q_stop > r_end;
        o_stat.shrink_left  = r_q_left > r_start;
        o_stat.shrink_right = r_q_stop < r_end;
        o_stat.win_open     = r_start < r_end;
        o_stat.out_free     = !r_out_valid || i_m_axis_tready;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_power);
    assign o_m_axis_tuser  = r_out_err;

endmodule

[sv/sliding_range_power_query.sv]
// top level of the sliding range power query block
// After reset the block zeroes all 65536 entries of its count table, one entry a cycle, with
// tready low. A query then walks the window to [left, right] one element at a time; each
// element added or removed goes through an element store read, a count table read, a multiply
// and a power and count update. A load first empties the open window element by element,
// then writes the store. A rejected query returns power 0 with range_error set. A load
// gives no result item. The result register lets the next item in while a result still
// waits to be taken.
module sliding_range_power_query
    import srq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // load_index, load_value, range_left, range_right, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // power
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // range_error
    output logic                  o_m_axis_tuser
);

    t_srq_cmd  w_cmd;
    t_srq_stat w_stat;

    srq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    srq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

[tb/tb_sliding_range_power_query.sv]
// self-checking testbench for the sliding range power query block
`timescale 1ns / 100ps

module tb_sliding_range_power_query;
    import srq_pkg::*;

    localparam logic RANGE_OK  = 1'b0;
    localparam logic RANGE_BAD = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int RAND_PER_PHASE = 277;
    localparam int FILL_DEPTH = 320;
    localparam logic [POW_W-1:0] FULL_POWER = 40'd6710784000;

    typedef struct packed {
        logic             bad;
        logic [POW_W-1:0] power;
    } t_power_result;

    typedef struct packed {
        logic          cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic          has_want;
        t_power_result want;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{CMD_QUERY, 12'd0, 16'd0, 12'd1, 12'd0, 1'b1, '{RANGE_BAD, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd4095, 12'd0, 1'b1, '{RANGE_BAD, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd4095, 12'd4094, 1'b1, '{RANGE_BAD, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd0, 12'd0, 1'b1, '{RANGE_OK, 40'd65535}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd0, 12'd319, 1'b1, '{RANGE_OK, FULL_POWER}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd319, 12'd319, 1'b1, '{RANGE_OK, 40'd65535}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd0, 12'd319, 1'b1, '{RANGE_OK, FULL_POWER}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd10, 12'd20, 1'b1, '{RANGE_OK, 40'd7929735}},
        '{CMD_LOAD, 12'd317, 16'd0, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'd318, 16'd1, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'h055, 16'hAAAA, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'h0AA, 16'h5555, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd317, 12'd319, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'd5, 16'd7, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'd6, 16'd7, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_LOAD, 12'd7, 16'd7, 12'd0, 12'd0, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd5, 12'd7, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd6, 12'd7, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd4, 12'd7, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd4, 12'd5, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'h055, 12'h0AA, 1'b0, '{RANGE_OK, 40'd0}},
        '{CMD_QUERY, 12'd0, 16'd0, 12'd160, 12'd160, 1'b0, '{RANGE_OK, 40'd0}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // load_index, load_value, range_left, range_right, zero pad
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    // command
    logic                  i_s_axis_tuser = CMD_LOAD;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // power
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // range_error
    logic                  o_m_axis_tuser;

    // predictor state
    logic [VAL_W-1:0]  elem_mem [ARRAY_DEPTH];
    int unsigned       value_count [VALUE_RANGE];
    int                win_lo = 0;
    int                win_hi = 0;
    longint unsigned   window_power = 0;

    t_power_result power_expect_q [$];
    int            mismatch_cnt = 0;
    int unsigned   cycle_cnt = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    sliding_range_power_query uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void add_element(input int pos);
        int unsigned     v;
        longint unsigned k;
        v = 32'(elem_mem[pos]);
        k = 64'(value_count[v]);
        window_power += (2 * k + 1) * longint'(v);
        value_count[v] = 32'(k + 1);
    endfunction

    function automatic void drop_element(input int pos);
        int unsigned     v;
        longint unsigned k;
        v = 32'(elem_mem[pos]);
        k = 64'(value_count[v]);
        if (k != 0) begin
            window_power -= (2 * k - 1) * longint'(v);
            value_count[v] = 32'(k - 1);
        end
    endfunction

    function automatic void predict_power(input logic cmd, input logic [IDX_W-1:0] idx,
                                          input logic [VAL_W-1:0] val,
                                          input logic [IDX_W-1:0] lo,
                                          input logic [IDX_W-1:0] hi,
                                          output bit has, output t_power_result res);
        int stop;
        has = 1'b0;
        res = '0;
        if (cmd == CMD_LOAD) begin
            while (win_lo < win_hi) begin
                drop_element(win_lo);
                win_lo++;
            end
            win_lo = 0;
            win_hi = 0;
            if (int'(idx) < ARRAY_DEPTH) begin
                elem_mem[idx] = val;
            end
        end else begin
            has = 1'b1;
            if (lo > hi || int'(hi) >= ARRAY_DEPTH) begin
                res.bad = RANGE_BAD;
            end else begin
                stop = int'(hi) + 1;
                while (int'(lo) < win_lo) begin
                    win_lo--;
                    add_element(win_lo);
                end
                while (stop > win_hi) begin
                    add_element(win_hi);
                    win_hi++;
                end
                while (int'(lo) > win_lo) begin
                    drop_element(win_lo);
                    win_lo++;
                end
                while (stop < win_hi) begin
                    win_hi--;
                    drop_element(win_hi);
                end
                res.bad = RANGE_OK;
                res.power = window_power[POW_W-1:0];
            end
        end
    endfunction

    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] lo,
                             input logic [IDX_W-1:0] hi, input logic has_want,
                             input t_power_result want);
        bit            has;
        t_power_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, hi, lo, val, idx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_power(cmd, idx, val, lo, hi, has, res);
        if (has) begin
            power_expect_q.push_back(has_want ? want : res);
        end
    endtask

    task automatic wait_drained();
        while (power_expect_q.size() != 0) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_power_result want;
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (power_expect_q.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("unexpected result: power %0d error %0b",
                                 o_m_axis_tdata[POW_W-1:0], o_m_axis_tuser);
                    end
                    mismatch_cnt++;
                end else begin
                    want = power_expect_q.pop_front();
                    if (o_m_axis_tdata[POW_W-1:0] !== want.power
                            || o_m_axis_tuser !== want.bad) begin
                        if (mismatch_cnt < 10) begin
                            $display("result mismatch: want power %0d error %0b, got %0d %0b",
                                     want.power, want.bad,
                                     o_m_axis_tdata[POW_W-1:0], o_m_axis_tuser);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("sliding_range_power_query regression: fail");
            $finish;
        end
    end

    initial begin
        int               r;
        int               phase;
        int               n;
        int               roll;
        int               gen_lo;
        int               gen_hi;
        bit               gen_open;
        int               new_lo;
        int               new_hi;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        t_power_result    none;
        gen_lo = 0;
        gen_hi = 0;
        gen_open = 1'b0;
        none = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the low part of the store; every window stays inside it
        for (r = 0; r < FILL_DEPTH; r++) begin
            send_item(CMD_LOAD, IDX_W'(r), 16'hFFFF, '0, '0, 1'b0, none);
        end
        for (r = 0; r < DIR_ROWS; r++) begin
            send_item(DIR_TABLE[r].cmd, DIR_TABLE[r].idx, DIR_TABLE[r].val,
                      DIR_TABLE[r].lo, DIR_TABLE[r].hi, DIR_TABLE[r].has_want,
                      DIR_TABLE[r].want);
        end

        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0) begin
                    wait_drained();
                end
                roll = $urandom_range(99);
                if (roll < 18) begin
                    idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(4095))
                                                   : IDX_W'($urandom_range(255));
                    case ($urandom_range(9))
                        0: val = '0;
                        1: val = '1;
                        2, 3, 4: val = VAL_W'(1 + $urandom_range(7));
                        default: val = VAL_W'($urandom);
                    endcase
                    send_item(CMD_LOAD, idx, val, IDX_W'($urandom), IDX_W'($urandom),
                              1'b0, none);
                    gen_open = 1'b0;
                end else if (roll < 26) begin
                    new_lo = $urandom_range(ARRAY_DEPTH - 1, 1);
                    new_hi = $urandom_range(new_lo - 1, 0);
                    send_item(CMD_QUERY, IDX_W'($urandom), VAL_W'($urandom), IDX_W'(new_lo),
                              IDX_W'(new_hi), 1'b0, none);
                end else begin
                    if (roll == 26) begin
                        new_lo = $urandom_range(FILL_DEPTH - 1);
                        new_hi = $urandom_range(FILL_DEPTH - 1, new_lo);
                    end else if (!gen_open) begin
                        new_lo = $urandom_range(255);
                        new_hi = new_lo + int'($urandom_range(63));
                    end else begin
                        new_lo = gen_lo + int'($urandom_range(12)) - 6;
                        new_hi = gen_hi + int'($urandom_range(12)) - 6;
                        if (new_lo < 0) new_lo = 0;
                        if (new_lo > FILL_DEPTH - 1) new_lo = FILL_DEPTH - 1;
                        if (new_hi > FILL_DEPTH - 1) new_hi = FILL_DEPTH - 1;
                        if (new_hi < new_lo) new_hi = new_lo;
                    end
                    gen_lo = new_lo;
                    gen_hi = new_hi;
                    gen_open = 1'b1;
                    send_item(CMD_QUERY, IDX_W'($urandom), VAL_W'($urandom), IDX_W'(new_lo),
                              IDX_W'(new_hi), 1'b0, none);
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        // a trailing load may still be emptying a full window
        repeat (4 * ARRAY_DEPTH + 64) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("sliding_range_power_query regression: pass");
        end else begin
            $display("sliding_range_power_query regression: fail");
        end
        $finish;
    end

endmodule
